@@ rtl/lcdn_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdn_pkg - shared types and constants for the character LCD nibble controller
// Command word passed from the byte classifier to the nibble sequencer, the
// power-up command table and default sizes.
// ----------------------------------------------------------------------------
package lcdn_pkg;

	localparam int unsigned INIT_LENGTH_DEF = 9;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	localparam int unsigned TABLE_LEN       = 9;
	localparam int unsigned INIT_IDX_W      = $clog2(TABLE_LEN);

	localparam logic [7:0] INIT_TABLE [TABLE_LEN] = '{
		8'h30, 8'h30, 8'h30, 8'h20, 8'h28, 8'h0C, 8'h06, 8'h01, 8'h02
	};

	localparam logic [7:0] CH_CLEAR   = 8'hFF;
	localparam logic [7:0] CH_HOME    = 8'h40;
	localparam logic [7:0] CMD_CLEAR  = 8'h01;
	localparam logic [7:0] CMD_HOME   = 8'h02;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_CTRL = 2'd1,
		OP_DATA = 2'd2
	} op_t;

	typedef struct packed {
		logic       do_init;
		op_t        op;
		logic [7:0] value;
	} cmd_t;

endpackage

@@ rtl/lcdn_in_if.sv @@
// ----------------------------------------------------------------------------
// lcdn_in_if - byte stream channel
// Valid/ready channel carrying one display byte per transaction.
// ----------------------------------------------------------------------------
interface lcdn_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink   (input valid, input ch, output ready);
endinterface

@@ rtl/lcdn_out_if.sv @@
// ----------------------------------------------------------------------------
// lcdn_out_if - nibble transfer channel
// Valid/ready channel carrying one LCD bus nibble per transaction.
// ----------------------------------------------------------------------------
interface lcdn_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] nibble;
	logic       reg_select;
	logic       last;

	modport source (output valid, output nibble, output reg_select, output last, input ready);
	modport sink   (input valid, input nibble, input reg_select, input last, output ready);
endinterface

@@ rtl/char_lcd_nibble_controller.sv @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_controller - 4-bit character LCD bus controller
// Turns display bytes into nibble transfers, with power-up sequence, clear,
// escape commands and 4-bit mode tracking.
//
//   channel   dir   payload                       transaction
//   in_ch     in    ch[7:0]                       valid & ready
//   out_nib   out   nibble[3:0], reg_select, last valid & ready
//   cfg       in    cfg_data[7:0] (escape_code)   cfg_we
//
// One nibble per cycle leaves the sequencer while the output is not stalled;
// a data byte is 2 nibbles, a control byte 1 or 2, the first byte after reset
// up to 16 nibbles (init table). The classifier takes a byte per cycle while
// the command queue has room. Reset is asynchronous and needs no clearing
// pass; the first byte after it carries the power-up sequence. Output stalls
// hold the output register and back up through the queue to in_ch.ready.
// ----------------------------------------------------------------------------
module char_lcd_nibble_controller #(
	parameter int unsigned INIT_LENGTH = lcdn_pkg::INIT_LENGTH_DEF,
	parameter int unsigned QUEUE_DEPTH = lcdn_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data,
	lcdn_in_if.sink     in_ch,
	lcdn_out_if.source  out_nib
);

	logic           q_push, q_pop, q_full, q_valid, in_ready;
	lcdn_pkg::cmd_t q_in, q_head;

	assign in_ch.ready = in_ready;

	lcdn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_ch.valid),
		.in_ch    (in_ch.ch),
		.q_full   (q_full),
		.in_ready (in_ready),
		.push     (q_push),
		.push_cmd (q_in)
	);

	lcdn_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_in),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_valid),
		.head_cmd   (q_head)
	);

	lcdn_back #(.INIT_LENGTH(INIT_LENGTH)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (q_valid),
		.head_cmd       (q_head),
		.pop            (q_pop),
		.out_valid      (out_nib.valid),
		.out_ready      (out_nib.ready),
		.out_nibble     (out_nib.nibble),
		.out_reg_select (out_nib.reg_select),
		.out_last       (out_nib.last)
	);

`ifndef SYNTHESIS
	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (in_ch.valid && in_ready && !q_full))
		else $error("queue push without accepted byte or with queue full");

	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue pop while empty");

	a_pop_loads_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (out_nib.valid && out_nib.last))
		else $error("command retired without a last nibble");

	a_data_rs: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !q_head.do_init && q_head.op == lcdn_pkg::OP_DATA) |=>
		out_nib.reg_select)
		else $error("data command finished on command register");
`endif

endmodule

@@ rtl/lcdn_front.sv @@
// ----------------------------------------------------------------------------
// lcdn_front - byte classifier
// Tracks power-up and escape phases and turns each byte into a command word.
// Bytes that cause no transfer are dropped here.
// ----------------------------------------------------------------------------
module lcdn_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	input  logic [7:0]         in_ch,
	input  logic               q_full,
	output logic               in_ready,
	output logic               push,
	output lcdn_pkg::cmd_t     push_cmd
);

	typedef enum logic [2:0] {
		PH_PWRUP  = 3'b001,
		PH_READY  = 3'b010,
		PH_ESCAPE = 3'b100
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] escape_q;
	logic       accept;
	lcdn_pkg::cmd_t cmd;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd.do_init = (phase_q == PH_PWRUP);
		cmd.op      = lcdn_pkg::OP_NONE;
		cmd.value   = in_ch;
		phase_d     = PH_READY;
		unique case (phase_q)
			PH_ESCAPE: begin
				if (in_ch[7]) begin
					cmd.op = lcdn_pkg::OP_CTRL;
				end else if (in_ch == lcdn_pkg::CH_HOME) begin
					cmd.op    = lcdn_pkg::OP_CTRL;
					cmd.value = lcdn_pkg::CMD_HOME;
				end
			end
			default: begin
				// clear test wins over a matching escape code
				if (in_ch == lcdn_pkg::CH_CLEAR) begin
					cmd.op    = lcdn_pkg::OP_CTRL;
					cmd.value = lcdn_pkg::CMD_CLEAR;
				end else if (in_ch == escape_q) begin
					phase_d = PH_ESCAPE;
				end else begin
					cmd.op = lcdn_pkg::OP_DATA;
				end
			end
		endcase
	end

	assign push     = accept && (cmd.do_init || cmd.op != lcdn_pkg::OP_NONE);
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PWRUP;
			escape_q <= 8'd27;
		end else begin
			if (accept) phase_q <= phase_d;
			if (cfg_we) escape_q <= cfg_data;
		end
	end

endmodule

@@ rtl/lcdn_fifo.sv @@
// ----------------------------------------------------------------------------
// lcdn_fifo - command queue
// Small register FIFO between the classifier and the nibble sequencer.
// ----------------------------------------------------------------------------
module lcdn_fifo #(
	parameter int unsigned DEPTH = lcdn_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lcdn_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output lcdn_pkg::cmd_t head_cmd
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	lcdn_pkg::cmd_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ rtl/lcdn_back.sv @@
// ----------------------------------------------------------------------------
// lcdn_back - nibble sequencer
// Walks the power-up table and the queued command, one nibble per cycle
// while not stalled, into the output register. Owns the 4-bit mode flag.
// ----------------------------------------------------------------------------
module lcdn_back #(
	parameter int unsigned INIT_LENGTH = lcdn_pkg::INIT_LENGTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  lcdn_pkg::cmd_t head_cmd,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [3:0]     out_nibble,
	output logic           out_reg_select,
	output logic           out_last
);

	localparam int unsigned IDX_W    = lcdn_pkg::INIT_IDX_W;
	localparam int unsigned INIT_LEN = (INIT_LENGTH > lcdn_pkg::TABLE_LEN) ?
	                                   lcdn_pkg::TABLE_LEN : INIT_LENGTH;

	logic [IDX_W-1:0] idx_q;
	logic             op_q;      // init part of head entry is done
	logic             low_q;     // next nibble is the low half
	logic             four_bit_q;
	logic             valid_q;
	logic [3:0]       nibble_q;
	logic             rs_q;
	logic             last_q;

	logic       cur_init, rs, high_only, byte_done, init_end, last, fire;
	logic [7:0] b;
	logic [3:0] nib;

	always_comb begin
		cur_init  = head_cmd.do_init && !op_q;
		b         = cur_init ? lcdn_pkg::INIT_TABLE[idx_q] : head_cmd.value;
		rs        = !cur_init && (head_cmd.op == lcdn_pkg::OP_DATA);
		high_only = !rs && !four_bit_q;
		byte_done = low_q || high_only;
		nib       = low_q ? b[3:0] : b[7:4];
		init_end  = cur_init && (idx_q == IDX_W'(INIT_LEN - 1));
		last      = byte_done && (!cur_init || (init_end && head_cmd.op == lcdn_pkg::OP_NONE));
		fire      = head_valid && (!valid_q || out_ready);
	end

	assign pop            = fire && last;
	assign out_valid      = valid_q;
	assign out_nibble     = nibble_q;
	assign out_reg_select = rs_q;
	assign out_last       = last_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			nibble_q <= nib;
			rs_q     <= rs;
			last_q   <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			op_q       <= 1'b0;
			low_q      <= 1'b0;
			four_bit_q <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			if (fire) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;

			if (fire) begin
				// function-set to 4-bit, seen as a lone high nibble
				if (!low_q && high_only && b[5:4] == 2'b10) four_bit_q <= 1'b1;
				low_q <= !byte_done;
				if (last) begin
					idx_q <= '0;
					op_q  <= 1'b0;
				end else if (byte_done && cur_init) begin
					if (init_end) begin
						idx_q <= '0;
						op_q  <= 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
			end
		end
	end

endmodule
